// ===== hdl/see_pkg.sv =====
// Shared types, constants and helper functions of the string escape encoder.
package see_pkg;

	// Escape queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;

	// Character codes
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CTRL_TOP  = 8'h20;
	localparam logic [7:0] CH_DEL    = 8'h7F;
	localparam logic [7:0] HI_MASK   = 8'hF0;
	localparam logic [7:0] LO_MASK   = 8'h0F;

	// Escape classes
	typedef enum logic [1:0] {
		K_PASS,  // byte goes out as is
		K_ESC2,  // backslash + letter
		K_HEXX,  // backslash x H H
		K_HEXU   // backslash u 0 0 H H
	} esc_kind_t;

	// Classified word carried through the queue
	typedef struct packed {
		esc_kind_t  kind;
		logic [7:0] ch;    // raw byte, or escape letter for K_ESC2
		logic       last;  // final byte of the string
	} esc_word_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] r;
		if (nib < 4'd10) begin
			r = CH_ZERO + {4'd0, nib};
		end else begin
			r = 8'h37 + {4'd0, nib};  // 'A' - 10
		end
		return r;
	endfunction

	// Number of characters minus one for a class
	function automatic logic [2:0] esc_len_m1(input esc_kind_t kind);
		logic [2:0] r;
		case (kind)
			K_PASS:  r = 3'd0;
			K_ESC2:  r = 3'd1;
			K_HEXX:  r = 3'd3;
			K_HEXU:  r = 3'd5;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/string_escape_encoder_core.sv =====
// Top level of the string escape encoder: front, queue and back wired together.
//
// Takes one raw byte per input word (with text/binary mode, invalid-UTF-8 and
// last-byte flags) and delivers its escaped form as 1 to 6 output words, one
// ASCII character each, upper-case hex. Both sides look like a queue: push/full
// on input, empty/pop on output. Rate: a byte that maps to one character flows
// at one word per cycle in and out while pop keeps up; an escaped byte yields 2
// (two-character escape), 4 (backslash x H H) or 6 (backslash u 0 0 H H)
// words, since the back-end sequencer emits one character per cycle unless the
// output is stalled. A 4-entry queue of classified words sits between the
// classifier and the sequencer, so input keeps flowing while an escape drains,
// and stops (full) only once that queue has filled. A pushed byte is written
// into the queue, then its first character to the output register. seq_last
// marks the final character of each byte; string_end is seq_last of a byte flagged last_byte.
module string_escape_encoder_core import see_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	// input side
	input  logic [7:0] in_byte,
	input  logic       bin_mode,
	input  logic       invalid_utf8,
	input  logic       last_byte,
	input  logic       push,
	output logic       full,
	// result side
	output logic [7:0] out_char,
	output logic       seq_last,
	output logic       string_end,
	output logic       empty,
	input  logic       pop
);

	esc_word_t front_word;
	esc_word_t head_word;
	logic      q_push;
	logic      q_full;
	logic      q_pop;
	logic      q_empty;

	// classify on the way in
	see_front u_front (
		.in_byte      (in_byte),
		.bin_mode     (bin_mode),
		.invalid_utf8 (invalid_utf8),
		.last_byte    (last_byte),
		.push         (push),
		.q_full       (q_full),
		.full         (full),
		.q_push       (q_push),
		.q_word       (front_word)
	);

	// decouples classification from character emission
	see_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_word (front_word),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_word (head_word),
		.empty   (q_empty)
	);

	// one character per cycle into the output register, unless the output is stalled
	see_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_word     (head_word),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.out_char   (out_char),
		.seq_last   (seq_last),
		.string_end (string_end),
		.empty      (empty),
		.pop        (pop)
	);

endmodule

// ===== hdl/see_front.sv =====
// Front end: accepts an input byte and classifies its escape form.
module see_front import see_pkg::*; (
	input  logic       [7:0] in_byte,
	input  logic             bin_mode,
	input  logic             invalid_utf8,
	input  logic             last_byte,
	input  logic             push,
	input  logic             q_full,
	output logic             full,
	output logic             q_push,
	output esc_word_t        q_word
);

	esc_kind_t  kind;
	logic [7:0] chv;

	always_comb begin
		kind = K_PASS;
		chv  = in_byte;
		if (invalid_utf8) begin
			kind = K_HEXX;
		end else begin
			case (in_byte)
				CH_DQUOTE: kind = bin_mode ? K_PASS : K_ESC2;
				CH_SQUOTE: kind = bin_mode ? K_ESC2 : K_PASS;
				CH_BSLASH: kind = K_ESC2;
				8'h09: begin
					kind = K_ESC2;
					chv  = CH_T;
				end
				8'h0D: begin
					kind = K_ESC2;
					chv  = CH_R;
				end
				8'h0A: begin
					kind = K_ESC2;
					chv  = CH_N;
				end
				8'h08: begin
					kind = K_ESC2;
					chv  = CH_B;
				end
				8'h0C: begin
					kind = K_ESC2;
					chv  = CH_F;
				end
				default: begin
					if (in_byte < CTRL_TOP || in_byte == CH_DEL) begin
						kind = bin_mode ? K_HEXX : K_HEXU;
					end
				end
			endcase
		end
	end

	assign full        = q_full;
	assign q_push      = push && !q_full;
	assign q_word.kind = kind;
	assign q_word.ch   = chv;
	assign q_word.last = last_byte;

endmodule

// ===== hdl/see_queue.sv =====
// Short queue of classified words between front and back.
module see_queue import see_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_en,
	input  esc_word_t wr_word,
	output logic      full,
	input  logic      rd_en,
	output esc_word_t rd_word,
	output logic      empty
);

	esc_word_t         mem_q [QDEPTH];
	logic [QPTR_W:0]   wr_ptr_q;
	logic [QPTR_W:0]   rd_ptr_q;
	logic [QPTR_W:0]   count;

	assign count   = wr_ptr_q - rd_ptr_q;
	assign full    = (count == (QPTR_W+1)'(QDEPTH));
	assign empty   = (count == '0);
	assign rd_word = mem_q[rd_ptr_q[QPTR_W-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd_en) rd_ptr_q <= rd_ptr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_ptr_q[QPTR_W-1:0]] <= wr_word;
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= (QPTR_W+1)'(QDEPTH)) else $error("queue count overflow");
	a_no_wr_full: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !full) else $error("write into full queue");
	a_no_rd_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !empty) else $error("read from empty queue");
`endif

endmodule

// ===== hdl/see_back.sv =====
// Back end: walks the escape sequence of the head word, one character per word out.
module see_back import see_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  esc_word_t  q_word,
	input  logic       q_empty,
	output logic       q_pop,
	output logic [7:0] out_char,
	output logic       seq_last,
	output logic       string_end,
	output logic       empty,
	input  logic       pop
);

	logic [2:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       seq_last_q;
	logic       string_end_q;

	logic       adv;
	logic       emit;
	logic       is_last;
	logic [2:0] len_m1;
	logic [7:0] hi;
	logic [7:0] lo;
	logic [7:0] nxt_char;

	assign adv     = !out_valid_q || pop;
	assign emit    = adv && !q_empty;
	assign len_m1  = esc_len_m1(q_word.kind);
	assign is_last = (idx_q == len_m1);
	assign q_pop   = emit && is_last;
	assign hi      = hex_char(q_word.ch[7:4]);
	assign lo      = hex_char(q_word.ch[3:0]);

	always_comb begin
		nxt_char = q_word.ch;
		case (q_word.kind)
			K_PASS: nxt_char = q_word.ch;
			K_ESC2: nxt_char = (idx_q == 3'd0) ? CH_BSLASH : q_word.ch;
			K_HEXX: begin
				case (idx_q)
					3'd0:    nxt_char = CH_BSLASH;
					3'd1:    nxt_char = CH_X;
					3'd2:    nxt_char = hi;
					default: nxt_char = lo;
				endcase
			end
			K_HEXU: begin
				case (idx_q)
					3'd0:    nxt_char = CH_BSLASH;
					3'd1:    nxt_char = CH_U;
					3'd2:    nxt_char = CH_ZERO;
					3'd3:    nxt_char = CH_ZERO;
					3'd4:    nxt_char = hi;
					default: nxt_char = lo;
				endcase
			end
			default: nxt_char = q_word.ch;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) out_valid_q <= !q_empty;
			if (emit) idx_q <= is_last ? 3'd0 : idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_char_q   <= nxt_char;
			seq_last_q   <= is_last;
			string_end_q <= is_last && q_word.last;
		end
	end

	assign out_char   = out_char_q;
	assign seq_last   = seq_last_q;
	assign string_end = string_end_q;
	assign empty      = !out_valid_q;

`ifndef NO_ASSERTIONS
	a_mid_seq_head: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != 3'd0) |-> !q_empty) else $error("head word lost mid-sequence");
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!q_empty |-> (idx_q <= len_m1)) else $error("index past sequence end");
	a_end_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && string_end_q) |-> seq_last_q) else $error("string end off last char");
`endif

endmodule

// ===== dv/string_escape_encoder_core_tb.sv =====
// Testbench for string_escape_encoder_core: directed and random bytes checked against a predictor.
`timescale 1ns / 100ps

module string_escape_encoder_core_tb;
	import see_pkg::*;

	// Control bytes with their own two-character escape
	localparam logic [7:0] CTL_BS  = 8'h08;
	localparam logic [7:0] CTL_TAB = 8'h09;
	localparam logic [7:0] CTL_LF  = 8'h0A;
	localparam logic [7:0] CTL_FF  = 8'h0C;
	localparam logic [7:0] CTL_CR  = 8'h0D;

	localparam int CLK_HALF       = 10;
	localparam int RST_CYCLES     = 10;
	localparam int RAND_BYTES     = 250;
	localparam int RX_HOLD_CYCLES = 300;  // long receiver hold-off for the fill-up test
	localparam int PRESSURE_BYTES = 24;
	localparam int TAIL_CYCLES    = 8;    // generous margin after the last owed word
	localparam int CYCLE_LIMIT    = 200000;
	localparam int MAX_PRINTS     = 30;

	// One expected output word: a character plus its two marker bits
	typedef struct packed {
		logic [7:0] ch;
		logic       seq_last;
		logic       string_end;
	} char_word_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic [7:0] in_byte = 8'h00;
	logic       bin_mode = 1'b0;
	logic       invalid_utf8 = 1'b0;
	logic       last_byte = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] out_char;
	logic       seq_last;
	logic       string_end;
	logic       empty;
	logic       pop = 1'b0;

	string      hex_tab = "0123456789ABCDEF";
	char_word_t escaped_chars[$];   // characters still owed by the block, oldest first

	int unsigned errors = 0;
	int unsigned n_bytes = 0;
	int unsigned n_escaped = 0;
	int unsigned n_invalid = 0;
	int unsigned n_chars = 0;
	int unsigned n_full_waits = 0;
	int unsigned cyc_count = 0;

	// Receiver side: stall pattern and long hold-off
	logic [15:0] rx_pat = 16'hFFFF;
	logic [15:0] rx_cyc = 16'd0;
	logic        rx_hold = 1'b0;
	bit          rx_hold_req = 1'b0;

	string_escape_encoder_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_byte      (in_byte),
		.bin_mode     (bin_mode),
		.invalid_utf8 (invalid_utf8),
		.last_byte    (last_byte),
		.push         (push),
		.full         (full),
		.out_char     (out_char),
		.seq_last     (seq_last),
		.string_end   (string_end),
		.empty        (empty),
		.pop          (pop)
	);

	initial begin
		forever begin
			#CLK_HALF clk = ~clk;
		end
	end

	// Watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cyc_count <= cyc_count + 1;
		if (cyc_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still owed", cyc_count,
				escaped_chars.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Predictor: escaped character sequence of one byte
	// ------------------------------------------------------------------
	// The invalid-UTF-8 flag wins over everything and gives backslash x H H in
	// both modes. Quote handling depends on mode: text escapes the double
	// quote, binary escapes the apostrophe. Remaining controls and DEL go to
	// backslash u 0 0 H H (text) or backslash x H H (binary). Bytes at 0x80 and
	// above pass unchanged unless flagged.
	task automatic predict_escape(input logic [7:0] b, input logic bm, input logic iv,
			input logic lb);
		logic [7:0] seq [6];
		logic [7:0] hi;
		logic [7:0] lo;
		char_word_t w;
		int n;
		hi = hex_tab[b[7:4]];
		lo = hex_tab[b[3:0]];
		n = 0;
		if (iv) begin
			seq[0] = CH_BSLASH; seq[1] = CH_X; seq[2] = hi; seq[3] = lo;
			n = 4;
		end else begin
			case (b)
				CH_DQUOTE: begin
					if (bm) begin
						seq[0] = CH_DQUOTE; n = 1;
					end else begin
						seq[0] = CH_BSLASH; seq[1] = CH_DQUOTE; n = 2;
					end
				end
				CH_SQUOTE: begin
					if (!bm) begin
						seq[0] = CH_SQUOTE; n = 1;
					end else begin
						seq[0] = CH_BSLASH; seq[1] = CH_SQUOTE; n = 2;
					end
				end
				CH_BSLASH: begin seq[0] = CH_BSLASH; seq[1] = CH_BSLASH; n = 2; end
				CTL_TAB:   begin seq[0] = CH_BSLASH; seq[1] = CH_T;      n = 2; end
				CTL_CR:    begin seq[0] = CH_BSLASH; seq[1] = CH_R;      n = 2; end
				CTL_LF:    begin seq[0] = CH_BSLASH; seq[1] = CH_N;      n = 2; end
				CTL_BS:    begin seq[0] = CH_BSLASH; seq[1] = CH_B;      n = 2; end
				CTL_FF:    begin seq[0] = CH_BSLASH; seq[1] = CH_F;      n = 2; end
				default: begin
					if (b < CTRL_TOP || b == CH_DEL) begin
						if (bm) begin
							seq[0] = CH_BSLASH; seq[1] = CH_X; seq[2] = hi; seq[3] = lo;
							n = 4;
						end else begin
							seq[0] = CH_BSLASH; seq[1] = CH_U; seq[2] = CH_ZERO;
							seq[3] = CH_ZERO; seq[4] = hi; seq[5] = lo;
							n = 6;
						end
					end else begin
						seq[0] = b; n = 1;
					end
				end
			endcase
		end
		for (int k = 0; k < n; k++) begin
			w.ch = seq[k];
			w.seq_last = (k == n - 1);
			w.string_end = (k == n - 1) && lb;
			escaped_chars.push_back(w);
		end
		if (n > 1) n_escaped++;
		if (iv) n_invalid++;
	endtask

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------
	// Offers one byte and returns at the edge that took it. push stays high on
	// return so back-to-back calls stream one word per cycle while full is low;
	// anything that lets time pass afterwards must go through idle_input first.
	task automatic send_byte(input logic [7:0] b, input logic bm, input logic iv,
			input logic lb);
		in_byte      <= b;
		bin_mode     <= bm;
		invalid_utf8 <= iv;
		last_byte    <= lb;
		push         <= 1'b1;
		@(posedge clk);
		while (full) begin
			n_full_waits++;
			@(posedge clk);
		end
		predict_escape(b, bm, iv, lb);
		n_bytes++;
	endtask

	task automatic idle_input(input int cycles);
		push <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (escaped_chars.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------
	// Stall pattern reloaded when rx_cyc[5:0] is zero; a quarter of the time it is
	// all ones so long stretches run without any stall.
	always @(posedge clk) begin
		rx_cyc <= rx_cyc + 16'd1;
		if (rx_cyc[5:0] == 6'd0) begin
			rx_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
		end
		pop <= !rx_hold && rx_pat[rx_cyc[3:0]];
	end

	// Long hold-off, counted here so the sender keeps pushing meanwhile
	initial begin
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				rx_hold <= 1'b1;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				rx_hold <= 1'b0;
				rx_hold_req = 1'b0;
			end
		end
	end

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		if (errors < MAX_PRINTS) begin
			$display("%0t: mismatch on %s: got 0x%02h, expected 0x%02h (word %0d)",
				$realtime, what, got, want, n_chars);
		end
		errors++;
	endtask

	// Every accepted word is compared with the oldest owed character
	char_word_t want_word;
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (escaped_chars.size() == 0) begin
				report_mismatch("unexpected word", out_char, 8'h00);
			end else begin
				want_word = escaped_chars.pop_front();
				if (out_char !== want_word.ch)
					report_mismatch("out_char", out_char, want_word.ch);
				if (seq_last !== want_word.seq_last)
					report_mismatch("seq_last", {7'd0, seq_last}, {7'd0, want_word.seq_last});
				if (string_end !== want_word.string_end)
					report_mismatch("string_end", {7'd0, string_end},
						{7'd0, want_word.string_end});
			end
			n_chars++;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Printable and high bytes, unflagged: single character out
	task automatic test_pass_through();
		send_byte(8'h20, 1'b0, 1'b0, 1'b0);
		send_byte(8'h41, 1'b1, 1'b0, 1'b0);
		send_byte(8'h7E, 1'b0, 1'b0, 1'b0);
		send_byte(8'h80, 1'b1, 1'b0, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b0, 1'b1);
		wait_drained();
	endtask

	// Quote rules swap with mode; backslash escapes in both
	task automatic test_quotes();
		send_byte(CH_DQUOTE, 1'b0, 1'b0, 1'b0);
		send_byte(CH_DQUOTE, 1'b1, 1'b0, 1'b0);
		send_byte(CH_SQUOTE, 1'b0, 1'b0, 1'b0);
		send_byte(CH_SQUOTE, 1'b1, 1'b0, 1'b1);
		send_byte(CH_BSLASH, 1'b0, 1'b0, 1'b0);
		send_byte(CH_BSLASH, 1'b1, 1'b0, 1'b1);
		wait_drained();
	endtask

	task automatic test_letter_escapes();
		send_byte(CTL_TAB, 1'b0, 1'b0, 1'b0);
		send_byte(CTL_CR,  1'b1, 1'b0, 1'b0);
		send_byte(CTL_LF,  1'b0, 1'b0, 1'b0);
		send_byte(CTL_BS,  1'b1, 1'b0, 1'b0);
		send_byte(CTL_FF,  1'b0, 1'b0, 1'b1);
		wait_drained();
	endtask

	// Other controls and DEL: long form in text, short hex form in binary
	task automatic test_hex_controls();
		send_byte(8'h00,   1'b0, 1'b0, 1'b0);
		send_byte(8'h00,   1'b1, 1'b0, 1'b0);
		send_byte(8'h1F,   1'b0, 1'b0, 1'b0);
		send_byte(8'h1B,   1'b1, 1'b0, 1'b0);
		send_byte(CH_DEL,  1'b0, 1'b0, 1'b0);
		send_byte(CH_DEL,  1'b1, 1'b0, 1'b1);
		wait_drained();
	endtask

	// Invalid flag overrides everything, text mode included
	task automatic test_invalid_flag();
		send_byte(8'hC3,     1'b0, 1'b1, 1'b0);
		send_byte(8'hFF,     1'b1, 1'b1, 1'b0);
		send_byte(CH_DQUOTE, 1'b0, 1'b1, 1'b0);
		send_byte(8'h00,     1'b0, 1'b1, 1'b1);
		wait_drained();
	endtask

	// Receiver holds off while the sender keeps offering control-byte escapes, so
	// the internal queue fills and full must hold the input back.
	task automatic test_backpressure();
		push <= 1'b0;
		rx_hold_req = 1'b1;
		do @(posedge clk); while (!rx_hold);
		for (int i = 0; i < PRESSURE_BYTES; i++) begin
			send_byte(8'($urandom_range(0, 31)), 1'($urandom), 1'b0,
				i == PRESSURE_BYTES - 1);
		end
		wait_drained();
	endtask

	function automatic logic [7:0] pick_byte();
		logic [7:0] specials [16] = '{8'h00, 8'h01, CTL_BS, CTL_TAB, CTL_LF, CTL_FF,
			CTL_CR, 8'h1F, 8'h20, CH_DQUOTE, CH_SQUOTE, CH_BSLASH, 8'h7E, CH_DEL,
			8'h80, 8'hFF};
		logic [7:0] r;
		if ($urandom_range(0, 9) < 4) r = specials[$urandom_range(0, 15)];
		else r = 8'($urandom);
		return r;
	endfunction

	// Strings of random length and mode with bursty input; some noise in the
	// mode bit and stray last-byte marks mid-string.
	task automatic test_random_strings();
		int unsigned sent;
		int unsigned burst_left;
		int unsigned len;
		logic bm;
		logic bm_now;
		logic iv;
		logic lb;
		sent = 0;
		burst_left = 0;
		while (sent < RAND_BYTES) begin
			len = $urandom_range(1, 12);
			bm = 1'($urandom);
			for (int i = 0; i < len; i++) begin
				if (burst_left == 0) begin
					if ($urandom_range(0, 9) >= 3) idle_input($urandom_range(1, 6));
					burst_left = $urandom_range(1, 20);
				end
				bm_now = ($urandom_range(0, 99) < 15) ? !bm : bm;
				iv = ($urandom_range(0, 99) < 10);
				lb = (i == len - 1) || ($urandom_range(0, 99) < 5);
				send_byte(pick_byte(), bm_now, iv, lb);
				burst_left--;
				sent++;
			end
		end
		wait_drained();
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (RST_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_pass_through();
		test_quotes();
		test_letter_escapes();
		test_hex_controls();
		test_invalid_flag();
		test_backpressure();
		test_random_strings();

		$display("bytes sent %0d: %0d escaped, %0d flagged invalid; words checked %0d",
			n_bytes, n_escaped, n_invalid, n_chars);
		$display("input held off by full for %0d cycles, %0d mismatches",
			n_full_waits, errors);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
